@@ hdl/ppc_pkg.sv @@
// package for the pyramid peak counter: shared constants, codes and types
// no dependencies; used by every other file of the block but ppc_ram
`timescale 1ns / 1ps

package ppc_pkg;

  // parameter defaults
  localparam int MAX_HALF_WIDTH_DEF = 8;
  localparam int PEAK_DEPTH_DEF     = 1024;
  localparam int SAMPLE_BITS_DEF    = 16;

  // fixed field widths
  localparam int THR_BITS   = 17;
  localparam int HW_BITS    = 4;
  localparam int COUNT_BITS = 11;
  localparam int CFG_IDX_BITS = 1;
  localparam int FRAC_SHIFT = 16;

  // configuration reset values
  localparam logic [THR_BITS-1:0] THR_RESET = 17'd655;
  localparam logic [HW_BITS-1:0]  HW_RESET  = 4'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD  = 1'b0,
    CFG_HALF_WIDTH = 1'b1
  } cfg_idx_t;

  // count pass sequencer states
  typedef enum logic [2:0] {
    CU_IDLE,
    CU_RANGE,
    CU_MUL,
    CU_SCAN,
    CU_DONE
  } cu_state_t;

  // window detector status toward the store stage
  typedef struct packed {
    logic valid;
    logic hit;
    logic last;
  } det_t;

  // count unit status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } cu_ctl_t;

endpackage

@@ hdl/ppc_in_if.sv @@
// sample input channel: valid/ready with one sample and the record end marker
// depends on ppc_pkg
`timescale 1ns / 1ps

interface ppc_in_if #(
  parameter int SAMPLE_BITS = ppc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

@@ hdl/ppc_out_if.sv @@
// result channel: valid/ready with the peak counts and overflow flag
// depends on ppc_pkg
`timescale 1ns / 1ps

interface ppc_out_if;
  import ppc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] peak_count;
  logic [COUNT_BITS-1:0] candidate_count;
  logic                  store_overflow;

  modport source (output valid, output peak_count, output candidate_count,
                  output store_overflow, input ready);
  modport sink   (input valid, input peak_count, input candidate_count,
                  input store_overflow, output ready);
endinterface

@@ hdl/ppc_cfg_if.sv @@
// configuration write channel: valid/ready with register index and data
// depends on ppc_pkg
`timescale 1ns / 1ps

interface ppc_cfg_if;
  import ppc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [THR_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ppc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ppc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/ppc_window.sv @@
// sliding sample window and pyramid shape test, registered detector output
// depends on ppc_pkg
`timescale 1ns / 1ps

module ppc_window #(
  parameter int MAX_HALF_WIDTH = ppc_pkg::MAX_HALF_WIDTH_DEF,
  parameter int SAMPLE_BITS    = ppc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic                                  last,
  input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]   hw,
  output ppc_pkg::det_t                         det_r,
  output logic signed [SAMPLE_BITS-1:0]         height_r
);
  import ppc_pkg::*;

  localparam int WIN_LEN = 2 * MAX_HALF_WIDTH + 1;
  localparam int FW      = $clog2(WIN_LEN + 1);
  localparam int IW      = $clog2(WIN_LEN);

  logic signed [SAMPLE_BITS-1:0] win_r [WIN_LEN];
  logic signed [SAMPLE_BITS-1:0] nw    [WIN_LEN];
  logic [FW-1:0]                 fill_r;
  logic [FW-1:0]                 fill_nxt;
  logic [FW-1:0]                 need;
  logic [WIN_LEN-2:0]            pair_ok;
  logic                          hit;

  // window as it stands once the new sample is in, index 0 newest
  always_comb begin
    nw[0] = sample;
    for (int k = 1; k < WIN_LEN; k++) begin
      nw[k] = win_r[k-1];
    end
  end

  // pairwise slope checks: falling side below hw, rising side below 2*hw
  always_comb begin
    for (int j = 0; j < WIN_LEN - 1; j++) begin
      if (j < int'(hw)) begin
        pair_ok[j] = nw[j+1] > nw[j];
      end else if (j < 2 * int'(hw)) begin
        pair_ok[j] = nw[j+1] < nw[j];
      end else begin
        pair_ok[j] = 1'b1;
      end
    end
  end

  // fill level and full-window qualification
  assign fill_nxt = (fill_r < FW'(WIN_LEN)) ? fill_r + 1'b1 : fill_r;
  assign need     = FW'({hw, 1'b1});
  assign hit      = (&pair_ok) && (fill_nxt >= need);

  // window shift register
  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_r[k] <= nw[k];
      end
      height_r <= nw[IW'(hw)];
    end
  end

  // fill count and detector status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      det_r  <= '0;
    end else begin
      det_r.valid <= push;
      det_r.hit   <= push && hit;
      det_r.last  <= push && last;
      if (push) begin
        fill_r <= last ? '0 : fill_nxt;
      end
    end
  end

endmodule

@@ hdl/ppc_count.sv @@
// count pass over the peak store: range, threshold product, then one read a cycle
// depends on ppc_pkg; drives the read port of the peak store ram
`timescale 1ns / 1ps

module ppc_count #(
  parameter int PEAK_DEPTH  = ppc_pkg::PEAK_DEPTH_DEF,
  parameter int SAMPLE_BITS = ppc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [$clog2(PEAK_DEPTH+1)-1:0]     snap_total,
  input  logic signed [SAMPLE_BITS-1:0]       snap_low,
  input  logic signed [SAMPLE_BITS-1:0]       snap_high,
  input  logic                                snap_ovf,
  input  logic [ppc_pkg::THR_BITS-1:0]        thr,
  input  logic                                out_free,
  output logic                                rd_en,
  output logic [$clog2(PEAK_DEPTH)-1:0]       rd_addr,
  input  logic signed [SAMPLE_BITS-1:0]       rd_data,
  output ppc_pkg::cu_ctl_t                    ctl,
  output logic [$clog2(PEAK_DEPTH+1)-1:0]     pass_count,
  output logic [$clog2(PEAK_DEPTH+1)-1:0]     cand_count,
  output logic                                ovf
);
  import ppc_pkg::*;

  localparam int TW = $clog2(PEAK_DEPTH + 1);
  localparam int AW = $clog2(PEAK_DEPTH);
  localparam int DW = SAMPLE_BITS + 1;
  localparam int CW = SAMPLE_BITS + THR_BITS + 1;

  cu_state_t                     state_r, state_nxt;
  logic [TW-1:0]                 total_r;
  logic signed [SAMPLE_BITS-1:0] low_r;
  logic signed [SAMPLE_BITS-1:0] high_r;
  logic                          ovf_r;
  logic [THR_BITS-1:0]           thr_r;
  logic [DW-1:0]                 range_r;
  logic [CW-1:0]                 limit_r;
  logic [TW-1:0]                 addr_r;
  logic                          pend_r;
  logic [TW-1:0]                 cnt_r;
  logic [DW-1:0]                 diff;
  logic [CW-1:0]                 rel;
  logic                          more;

  assign more = addr_r < total_r;
  assign diff = DW'({rd_data[SAMPLE_BITS-1], rd_data} - {low_r[SAMPLE_BITS-1], low_r});
  assign rel  = CW'({diff, FRAC_SHIFT'(0)});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CU_IDLE:  if (start) state_nxt = CU_RANGE;
      CU_RANGE: state_nxt = CU_MUL;
      CU_MUL:   state_nxt = CU_SCAN;
      CU_SCAN:  if (!more && !pend_r) state_nxt = CU_DONE;
      CU_DONE:  if (out_free) state_nxt = CU_IDLE;
      default:  state_nxt = CU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_en    = 1'b0;
    ctl.busy = 1'b1;
    ctl.done = 1'b0;
    unique case (state_r)
      CU_IDLE:  ctl.busy = 1'b0;
      CU_SCAN:  rd_en = more;
      CU_DONE:  ctl.done = out_free;
      default:  ctl.busy = 1'b1;
    endcase
  end

  assign rd_addr    = addr_r[AW-1:0];
  assign pass_count = cnt_r;
  assign cand_count = total_r;
  assign ovf        = ovf_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CU_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
    end
  end

  // snapshot, range, threshold product and scan datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      CU_IDLE: begin
        if (start) begin
          total_r <= snap_total;
          low_r   <= snap_low;
          high_r  <= snap_high;
          ovf_r   <= snap_ovf;
          thr_r   <= thr;
        end
      end
      CU_RANGE: begin
        range_r <= DW'({high_r[SAMPLE_BITS-1], high_r} - {low_r[SAMPLE_BITS-1], low_r});
      end
      CU_MUL: begin
        limit_r <= CW'(thr_r) * CW'(range_r);
        addr_r  <= '0;
        cnt_r   <= '0;
      end
      CU_SCAN: begin
        if (rd_en) begin
          addr_r <= addr_r + 1'b1;
        end
        if (pend_r && (rel > limit_r)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      CU_DONE: begin
        cnt_r <= cnt_r;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

@@ hdl/pyramid_peak_counter.sv @@
// pyramid peak counter top level: config registers, peak store and result register
// depends on ppc_pkg, the three channel interfaces, ppc_window, ppc_count, ppc_ram
//
// Usage
//   in_ch  : one signed sample per transfer, last_sample marks the end of a record.
//            Non-final samples are taken one per cycle while no count pass runs.
//   out_ch : one transfer per record, issued after the final sample: peaks above
//            the relative threshold, pyramid peaks stored, and the overflow flag.
//   cfg_ch : index 0 threshold_fraction (Q1.16), index 1 half_width; always ready.
//            Write only while no record result is outstanding.
// Operation
//   A sample is tested as it transfers; the detector result is registered, then
//   a peak is written into the store. The final sample starts a count pass that
//   reads one stored peak per cycle from the store ram; out_ch.valid rises after
//   the range, product and scan steps; in_ch is not ready meanwhile.
// Reset
//   rst_n clears the window fill, peak count, min/max and flags; the peak store
//   ram is not cleared, entries above the peak count are never read.
// Stall
//   The result waits in the output register while out_ch.ready is low; a further
//   result waits in the count unit and in_ch stays not ready until it is taken.
`timescale 1ns / 1ps

module pyramid_peak_counter #(
  parameter int MAX_HALF_WIDTH = ppc_pkg::MAX_HALF_WIDTH_DEF,
  parameter int PEAK_DEPTH     = ppc_pkg::PEAK_DEPTH_DEF,
  parameter int SAMPLE_BITS    = ppc_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ppc_in_if.sink      in_ch,
  ppc_out_if.source   out_ch,
  ppc_cfg_if.sink     cfg_ch
);
  import ppc_pkg::*;

  localparam int TW  = $clog2(PEAK_DEPTH + 1);
  localparam int AW  = $clog2(PEAK_DEPTH);
  localparam int HWB = $clog2(MAX_HALF_WIDTH + 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic [THR_BITS-1:0]           thr_r;
  logic [HW_BITS-1:0]            hw_r;
  logic [HWB-1:0]                hw_eff;
  logic                          in_xfer;
  logic                          busy_r;
  det_t                          det;
  logic signed [SAMPLE_BITS-1:0] height;
  logic [TW-1:0]                 total_r, total_nxt;
  logic signed [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic signed [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          store;
  logic                          ram_rd_en;
  logic [AW-1:0]                 ram_rd_addr;
  logic signed [SAMPLE_BITS-1:0] ram_rd_data;
  cu_ctl_t                       cu_ctl;
  logic [TW-1:0]                 cu_pass;
  logic [TW-1:0]                 cu_cand;
  logic                          cu_ovf;
  logic                          out_free;
  logic                          out_valid_r;
  logic [TW+COUNT_BITS-1:0]      pass_wide;
  logic [TW+COUNT_BITS-1:0]      cand_wide;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      hw_r  <= HW_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_THRESHOLD:  thr_r <= cfg_ch.data;
        CFG_HALF_WIDTH: hw_r  <= cfg_ch.data[HW_BITS-1:0];
        default:        thr_r <= thr_r;
      endcase
    end
  end

  // half width clamped into 1..MAX_HALF_WIDTH
  always_comb begin
    if (hw_r == '0) begin
      hw_eff = HWB'(1);
    end else if (int'(hw_r) > MAX_HALF_WIDTH) begin
      hw_eff = HWB'(MAX_HALF_WIDTH);
    end else begin
      hw_eff = HWB'(hw_r);
    end
  end

  // input handshake: one record at a time
  assign in_ch.ready = !busy_r;
  assign in_xfer     = in_ch.valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer && in_ch.last_sample) begin
      busy_r <= 1'b1;
    end else if (cu_ctl.done) begin
      busy_r <= 1'b0;
    end
  end

  ppc_window #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .sample   (in_ch.sample),
    .last     (in_ch.last_sample),
    .hw       (hw_eff),
    .det_r    (det),
    .height_r (height)
  );

  // peak store update and running min/max
  assign store = det.hit && (total_r < TW'(PEAK_DEPTH));

  always_comb begin
    total_nxt = total_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    ovf_nxt   = ovf_r;
    if (store) begin
      total_nxt = total_r + 1'b1;
      if (height > high_r) high_nxt = height;
      if (height < low_r)  low_nxt  = height;
    end else if (det.hit) begin
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (det.valid && det.last)) begin
      total_r <= '0;
      high_r  <= S_MIN;
      low_r   <= S_MAX;
      ovf_r   <= 1'b0;
    end else begin
      total_r <= total_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  ppc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (PEAK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (total_r[AW-1:0]),
    .wr_data (height),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ppc_count #(
    .PEAK_DEPTH  (PEAK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (det.valid && det.last),
    .snap_total (total_nxt),
    .snap_low   (low_nxt),
    .snap_high  (high_nxt),
    .snap_ovf   (ovf_nxt),
    .thr        (thr_r),
    .out_free   (out_free),
    .rd_en      (ram_rd_en),
    .rd_addr    (ram_rd_addr),
    .rd_data    (ram_rd_data),
    .ctl        (cu_ctl),
    .pass_count (cu_pass),
    .cand_count (cu_cand),
    .ovf        (cu_ovf)
  );

  // result register
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pass_wide = {COUNT_BITS'(0), cu_pass};
  assign cand_wide = {COUNT_BITS'(0), cu_cand};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cu_ctl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cu_ctl.done) begin
      out_ch.peak_count      <= pass_wide[COUNT_BITS-1:0];
      out_ch.candidate_count <= cand_wide[COUNT_BITS-1:0];
      out_ch.store_overflow  <= cu_ovf;
    end
  end

  assign out_ch.valid = out_valid_r;

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(PEAK_DEPTH))
    else $error("peak total beyond store depth");

  a_no_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    cu_ctl.busy |-> !store)
    else $error("peak store written during count pass");

  a_pass_le_cand: assert property (@(posedge clk) disable iff (!rst_n)
    cu_ctl.done |-> (cu_pass <= cu_cand))
    else $error("passing peaks exceed stored peaks");

  a_last_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (det.valid && det.last) |-> busy_r)
    else $error("input open while record end is in flight");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cu_ctl.done |=> out_valid_r)
    else $error("count result not registered");

endmodule
